FILE: hdl/sfr_pkg.sv
// Shared constants, result type and CRC byte update for the stuffed frame receiver.
package sfr_pkg;

    localparam logic [7:0]  START_MARK = 8'hFA;
    localparam logic [15:0] CRC_POLY   = 16'hA001;
    localparam logic [7:0]  STUFF_POS  = 8'd4;
    localparam logic [7:0]  LEN_POS    = 8'd5;
    localparam logic [8:0]  CRC_TAIL   = 9'd5;
    localparam logic [8:0]  LAST_TAIL  = 9'd7;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic [7:0]  byte_index;
        logic        frame_done;
        logic        crc_ok;
        logic [15:0] crc_value;
    } result_t;

    // Reflected CRC-16, one byte, LSB first.
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

FILE: hdl/stuffed_frame_receiver_crc16_unit.sv
// Top level of the byte-stuffed frame receiver with CRC-16 check.
//
// Receives serial bytes one item at a time and rebuilds frames that open with
// 0xFA. A wrong byte at the start position is dropped. From position 4 on, a
// 0xFA is a stuffing mark that is dropped, and the 0xFA after it is kept as
// data. Position 5 carries the payload length in BCD (tens*10+units); the frame
// ends at kept position 7+len. A reflected CRC-16 (poly 0xA001, init 0, no final
// xor) runs over kept positions 1 through 5+len, and its low byte is compared
// with the final byte (crc_ok, valid with frame_done). Each kept byte produces
// one output item carrying the byte, its frame position and the running CRC;
// dropped bytes produce nothing. After the last byte the frame state clears.
// Throughput is one item per clock while out_ready does not stall the output:
// each byte sits in an input register, the byte-wide CRC update and frame
// checks run combinationally, and the result lands in an output register,
// which raises out_valid when the staged byte advances.
// A dropped byte retires even while the output register is held by a stall.
module stuffed_frame_receiver_crc16_unit
    import sfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  data_byte,
    output logic [7:0]  byte_index,
    output logic        frame_done,
    output logic        crc_ok,
    output logic [15:0] crc_value
);

    logic       stage_valid_reg;
    logic [7:0] stage_byte_reg;
    logic       out_valid_reg;
    result_t    out_reg;

    logic       keep;
    logic       out_free;
    logic       advance;
    result_t    res;

    // output slot can take a new item when empty or draining this cycle
    assign out_free = !out_valid_reg || out_ready;
    // a staged byte retires when it needs no slot or the slot is free
    assign advance  = stage_valid_reg && (!keep || out_free);
    assign in_ready = !stage_valid_reg || advance;

    sfr_deframer u_deframer (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .rx_byte (stage_byte_reg),
        .keep    (keep),
        .res     (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            stage_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            stage_byte_reg <= rx_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && keep)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && keep)
            out_reg <= res;
    end

    assign out_valid  = out_valid_reg;
    assign data_byte  = out_reg.data_byte;
    assign byte_index = out_reg.byte_index;
    assign frame_done = out_reg.frame_done;
    assign crc_ok     = out_reg.crc_ok;
    assign crc_value  = out_reg.crc_value;

endmodule

FILE: hdl/sfr_deframer.sv
// Frame state, destuffing, length decode and CRC accumulation for one byte per cycle while step is high.
module sfr_deframer
    import sfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic [7:0]  rx_byte,
    output logic        keep,
    output result_t     res
);

    logic [7:0]  count_reg;
    logic        stuff_reg;
    logic [15:0] crc_reg;
    logic [7:0]  len_reg;

    logic        is_mark;
    logic        drop_start;
    logic        drop_stuff;
    logic [7:0]  bcd_len;
    logic [7:0]  len_next;
    logic [8:0]  len9;
    logic        crc_en;
    logic [15:0] crc_next;
    logic        done;

    assign is_mark    = (rx_byte == START_MARK);
    assign drop_start = (count_reg == 8'd0) && !is_mark;
    assign drop_stuff = (count_reg >= STUFF_POS) && is_mark && !stuff_reg;
    assign keep       = !drop_start && !drop_stuff;

    // tens*10 + units; non-decimal nibbles go through unchanged
    assign bcd_len  = ({4'd0, rx_byte[7:4]} << 3) + ({4'd0, rx_byte[7:4]} << 1)
                    + {4'd0, rx_byte[3:0]};
    assign len_next = (count_reg == LEN_POS) ? bcd_len : len_reg;
    assign len9     = {1'b0, len_next};

    assign crc_en   = (count_reg != 8'd0)
                   && ((count_reg <= LEN_POS) || ({1'b0, count_reg} <= CRC_TAIL + len9));
    assign crc_next = crc_en ? crc_feed(crc_reg, rx_byte) : crc_reg;
    assign done     = (count_reg >= LEN_POS) && ({1'b0, count_reg} == LAST_TAIL + len9);

    always_comb
    begin
        res.data_byte  = rx_byte;
        res.byte_index = count_reg;
        res.frame_done = done;
        res.crc_ok     = done && (crc_next[7:0] == rx_byte);
        res.crc_value  = crc_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 8'd0;
            stuff_reg <= 1'b0;
            crc_reg   <= 16'd0;
            len_reg   <= 8'd0;
        end
        else if (step)
        begin
            if (drop_stuff)
            begin
                stuff_reg <= 1'b1;
            end
            else if (keep)
            begin
                if (done)
                begin
                    count_reg <= 8'd0;
                    stuff_reg <= 1'b0;
                    crc_reg   <= 16'd0;
                    len_reg   <= 8'd0;
                end
                else
                begin
                    count_reg <= count_reg + 8'd1;
                    if ((count_reg >= STUFF_POS) && is_mark)
                        stuff_reg <= 1'b0;
                    crc_reg <= crc_next;
                    len_reg <= len_next;
                end
            end
        end
    end

endmodule

FILE: tb/frame_check_pkg.sv
// CRC helper and result scoreboard for the stuffed frame receiver testbench.
package frame_check_pkg;

    import sfr_pkg::*;

    // Reflected CRC-16, fed one data bit at a time, LSB first.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        bit          fb;
        c = crc;
        for (int i = 0; i < 8; i++)
        begin
            fb = c[0] ^ b[i];
            c  = c >> 1;
            if (fb)
                c = c ^ CRC_POLY;
        end
        return c;
    endfunction

    class frame_scoreboard;

        logic [7:0]  kept_cnt;
        bit          mark_pend;
        logic [15:0] crc_run;
        logic [7:0]  len_dec;
        result_t     due_q[$];
        int          mismatches;
        int          kept_total;

        function new();
            clear_frame();
            mismatches = 0;
            kept_total = 0;
        endfunction

        function void clear_frame();
            kept_cnt  = 8'd0;
            mark_pend = 1'b0;
            crc_run   = 16'd0;
            len_dec   = 8'd0;
        endfunction

        // Accepted byte: work out the item it should produce, if any.
        function void note_byte(input logic [7:0] b);
            result_t r;
            int      span;
            if (kept_cnt == 8'd0 && b != START_MARK)
                return;
            if (kept_cnt >= STUFF_POS && b == START_MARK)
            begin
                if (!mark_pend)
                begin
                    mark_pend = 1'b1;
                    return;
                end
                mark_pend = 1'b0;
            end
            if (kept_cnt == LEN_POS)
                len_dec = 8'(b[7:4] * 10 + b[3:0]);
            span = int'(len_dec);
            if (kept_cnt >= 8'd1 && int'(kept_cnt) <= 5 + span)
                crc_run = crc_byte(crc_run, b);
            r.data_byte  = b;
            r.byte_index = kept_cnt;
            r.frame_done = (int'(kept_cnt) == 7 + span);
            r.crc_ok     = r.frame_done && (crc_run[7:0] == b);
            r.crc_value  = crc_run;
            due_q.push_back(r);
            kept_total++;
            if (r.frame_done)
                clear_frame();
            else
                kept_cnt++;
        endfunction

        function void check_result(input result_t got);
            result_t want;
            if (due_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected item: byte %02h index %0d done %0b ok %0b crc %04h",
                             got.data_byte, got.byte_index, got.frame_done, got.crc_ok,
                             got.crc_value);
                return;
            end
            want = due_q.pop_front();
            if (got.data_byte !== want.data_byte || got.byte_index !== want.byte_index ||
                got.frame_done !== want.frame_done || got.crc_ok !== want.crc_ok ||
                got.crc_value !== want.crc_value)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected byte %02h index %0d done %0b ok %0b crc %04h,",
                             want.data_byte, want.byte_index, want.frame_done, want.crc_ok,
                             want.crc_value,
                             " got byte %02h index %0d done %0b ok %0b crc %04h",
                             got.data_byte, got.byte_index, got.frame_done,
                             got.crc_ok, got.crc_value);
            end
        endfunction

        function int pending();
            return due_q.size();
        endfunction

        function logic [7:0] frame_pos();
            return kept_cnt;
        endfunction

        function bit stuff_armed();
            return mark_pend;
        endfunction

    endclass

endpackage

FILE: tb/tb_top.sv
// Testbench top: drives byte streams into the stuffed frame receiver and checks every item out.
module tb_top;

    import sfr_pkg::*;
    import frame_check_pkg::*;

    // Generous cycle budget; a normal run needs a small fraction of this.
    localparam int CYCLE_LIMIT = 400000;
    // Kept bytes per random phase.
    localparam int PHASE_ITEMS = 100;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic [7:0]  rx_byte   = 8'h00;
    logic        out_ready = 1'b0;
    logic        in_ready;
    logic        out_valid;
    logic [7:0]  data_byte;
    logic [7:0]  byte_index;
    logic        frame_done;
    logic        crc_ok;
    logic [15:0] crc_value;

    int              cycles         = 0;
    int              send_idle_pct  = 0;
    int              recv_stall_pct = 0;
    frame_scoreboard sb;

    // Kept (destuffed) bytes of the frame being built; stuffing marks are added on send.
    logic [7:0]      frame_q[$];

    stuffed_frame_receiver_crc16_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .data_byte  (data_byte),
        .byte_index (byte_index),
        .frame_done (frame_done),
        .crc_ok     (crc_ok),
        .crc_value  (crc_value)
    );

    always #5 clk = ~clk;

    // Receiver side: ready is redrawn every falling edge, so stalls hit any
    // phase of the pipeline. With a zero stall rate ready simply stays high.
    always @(negedge clk)
        out_ready = ($urandom_range(0, 99) >= recv_stall_pct);

    // Output monitor. Sampling at the rising edge sees the values settled
    // during the previous half cycle, before the block's registers update.
    always @(posedge clk)
    begin
        cycles++;
        if (rst_n && out_valid && out_ready)
            sb.check_result(result_t'({data_byte, byte_index, frame_done, crc_ok, crc_value}));
    end

    // Hang guard.
    initial
    begin : watchdog
        while (cycles < CYCLE_LIMIT)
            @(posedge clk);
        $display("TB_ERROR");
        $finish;
    end

    // Data bytes lean toward the start/stuff mark and the extremes so that
    // stuffing shows up often in payloads and headers.
    function automatic logic [7:0] rand_data();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20)
            return START_MARK;
        else if (r < 25)
            return 8'h00;
        else if (r < 30)
            return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    // Append CRC high and low bytes; the CRC covers kept positions 1..5+len.
    // A bad frame gets an inverted low byte, so the check must fail.
    function automatic void seal_frame(input bit bad);
        logic [15:0] c;
        c = 16'h0000;
        for (int i = 1; i < frame_q.size(); i++)
            c = crc_byte(c, frame_q[i]);
        frame_q.push_back(c[15:8]);
        frame_q.push_back(bad ? ~c[7:0] : c[7:0]);
    endfunction

    // Random well-formed frame. The length byte is mostly small BCD, sometimes
    // carries a non-decimal units nibble, and rarely is 0xFF (length 165).
    function automatic void make_frame();
        int         r;
        int         plen;
        logic [7:0] lb;
        frame_q.delete();
        frame_q.push_back(START_MARK);
        repeat (4)
            frame_q.push_back(rand_data());
        r = $urandom_range(0, 99);
        if (r < 3)
            lb = 8'hFF;
        else if (r < 15)
            lb = {4'($urandom_range(0, 1)), 4'($urandom_range(10, 15))};
        else
            lb = {4'($urandom_range(0, 1)), 4'($urandom_range(0, 9))};
        frame_q.push_back(lb);
        plen = lb[7:4] * 10 + lb[3:0];
        repeat (plen)
            frame_q.push_back(rand_data());
        seal_frame($urandom_range(0, 9) == 0);
    endfunction

    // One input item. Inputs change on the falling edge; the item counts as
    // taken at the first rising edge with ready high. Valid is left high on
    // return, so the caller either sends again or lowers it before waiting.
    task automatic send_byte(input logic [7:0] b);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        rx_byte  = b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_byte(b);
    endtask

    // Send frame_q with stuffing: from position 4 on, a 0xFA goes out behind
    // a mark unless a mark is already armed. stop_at cuts the frame short;
    // stray_at puts an extra mark before that position, which stays armed
    // across non-0xFA bytes until the next 0xFA.
    task automatic send_frame(input int stop_at, input int stray_at);
        for (int i = 0; i < frame_q.size(); i++)
        begin
            if (i == stop_at)
                break;
            if (i == stray_at)
                send_byte(START_MARK);
            if (i >= int'(STUFF_POS) && frame_q[i] == START_MARK && !sb.stuff_armed())
                send_byte(START_MARK);
            send_byte(frame_q[i]);
        end
    endtask

    // Drop valid and hold off until every expected item has come out.
    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int send_tbl[4];
        int recv_tbl[4];
        int start_total;
        int pick;
        int stray;
        send_tbl = '{0, 72, 0, 34};
        recv_tbl = '{0, 0, 72, 34};
        sb = new();

        repeat (3)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: wrong start bytes are dropped.
        send_byte(8'h00);
        send_byte(8'h55);

        // Directed: 0xFA as data at positions 1-3 (no stuffing), stuffed 0xFA
        // at position 4, zero length, good CRC.
        frame_q = '{START_MARK, START_MARK, START_MARK, START_MARK, START_MARK, 8'h00};
        seal_frame(1'b0);
        send_frame(-1, -1);

        // Directed: non-decimal length 0x0A, extreme data values, a mark armed
        // ahead of non-0xFA bytes, and a wrong CRC low byte.
        frame_q = '{START_MARK, 8'h01, 8'h02, 8'h03, 8'h04, 8'h0A,
                    8'h00, 8'hFF, START_MARK, 8'h55, 8'hAA, 8'h80, 8'h7F,
                    START_MARK, 8'h01, 8'hFE};
        seal_frame(1'b1);
        send_frame(-1, 6);

        // Sender holds off until the pipeline is empty.
        drain();

        // Random phases with different idle/stall mixes. Most traffic is
        // well-formed frames; the rest are cut frames and line noise. After
        // each, filler bytes push the block back to the frame start.
        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct  = send_tbl[p];
            recv_stall_pct = recv_tbl[p];
            start_total    = sb.kept_total;
            while (sb.kept_total - start_total < PHASE_ITEMS)
            begin
                pick = $urandom_range(0, 99);
                make_frame();
                if (pick < 75)
                begin
                    stray = ($urandom_range(0, 19) == 0) ?
                            int'($urandom_range(4, frame_q.size() - 1)) : -1;
                    send_frame(-1, stray);
                end
                else if (pick < 90)
                    send_frame(int'($urandom_range(1, frame_q.size() - 2)), -1);
                else
                    repeat ($urandom_range(1, 4))
                        send_byte(8'($urandom_range(0, 255)));
                while (sb.frame_pos() != 8'd0)
                    send_byte(rand_data());
            end
            drain();
        end

        // Let the clock run on to catch any stray item.
        repeat (10)
            @(posedge clk);
        if (sb.mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
